[hdl/bpc_pkg.sv]
// Shared types, constants and fixed-point helpers for the barometer compensation block.
// Used by every module under hdl; depends on nothing else.
package bpc_pkg;

    // Fixed-point format of internal values: signed 64 bit, FRAC_BITS fraction bits
    localparam int FRAC_BITS = 32;

    // Pipeline timing (stage numbers count registers passed since the input beat)
    localparam int LAT_MUL    = 4;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = 64 / DIV_STEP;
    localparam int LAT_DIV    = DIV_STAGES + 3;
    localparam int S_TF       = 5;
    localparam int S_POST1    = S_TF + LAT_MUL + 1;
    localparam int S_POST2    = S_POST1 + LAT_MUL + 1;
    localparam int S_N        = S_POST2 + 1;
    localparam int S_DP       = S_N + LAT_MUL;
    localparam int S_PF       = S_DP + LAT_DIV;
    localparam int S_PR1      = S_PF + LAT_MUL + 1;
    localparam int S_PR2      = S_PR1 + LAT_MUL + 1;
    localparam int S_OUT      = S_PR2 + 1;
    localparam int LATENCY    = S_OUT;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_TRIM  = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_MID  = 2'd2;
    localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

    typedef logic signed [63:0]  t_q;
    typedef logic signed [127:0] t_prod;

    localparam t_q Q_MAX  = {1'b0, {63{1'b1}}};
    localparam t_q Q_MIN  = {1'b1, {63{1'b0}}};
    localparam t_q TF_OFS = t_q'(128000) <<< FRAC_BITS;

    localparam logic signed [14:0] CENTI_MIN = -15'sd4000;
    localparam logic signed [14:0] CENTI_MAX = 15'sd8500;
    localparam logic [24:0]        PRESS_MAX = {25{1'b1}};

    typedef struct packed {
        logic [7:0] press_msb;
        logic [7:0] press_lsb;
        logic [7:0] press_xlsb;
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_xlsb;
    } t_in;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [24:0]        pressure_q8;
        logic               divide_fault;
    } t_out;

    // Saturate a wide signed value to the 64-bit range
    function automatic t_q f_sat(input t_prod x);
        logic fits;
        fits = (&x[127:63]) | ~(|x[127:63]);
        if (fits) begin
            return x[63:0];
        end
        return x[127] ? Q_MIN : Q_MAX;
    endfunction

    // Saturating 64-bit add
    function automatic t_q f_add(input t_q a, input t_q b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

endpackage

[hdl/bpc_mul.sv]
// Pipelined 64x64 signed multiplier, exact 128-bit product, four stages.
// Built from 32x32 partial products; uses bpc_pkg types.
module bpc_mul (
    input  logic              i_clk,
    input  bpc_pkg::t_q       i_a,
    input  bpc_pkg::t_q       i_b,
    output bpc_pkg::t_prod    o_p
);

    logic [63:0]    r_ma;
    logic [63:0]    r_mb;
    logic [2:0]     r_neg;
    logic [63:0]    r_p00;
    logic [63:0]    r_p01;
    logic [63:0]    r_p10;
    logic [63:0]    r_p11;
    logic [127:0]   r_sum;
    bpc_pkg::t_prod r_p;

    // magnitudes, then partial products, then sum, then sign
    always_ff @(posedge i_clk) begin
        r_ma  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
        r_mb  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        r_neg <= {r_neg[1:0], i_a[63] ^ i_b[63]};
        r_p00 <= r_ma[31:0]  * r_mb[31:0];
        r_p01 <= r_ma[31:0]  * r_mb[63:32];
        r_p10 <= r_ma[63:32] * r_mb[31:0];
        r_p11 <= r_ma[63:32] * r_mb[63:32];
        r_sum <= 128'(r_p00) + (128'(r_p01) << 32) + (128'(r_p10) << 32)
                 + (128'(r_p11) << 64);
        r_p   <= r_neg[2] ? bpc_pkg::t_prod'(-r_sum) : bpc_pkg::t_prod'(r_sum);
    end

    assign o_p = r_p;

endmodule

[hdl/bpc_temp.sv]
// Temperature front end: raw offset, polynomial, fine temperature and centi-degrees.
// Five register stages; uses bpc_pkg.
module bpc_temp (
    input  logic                i_clk,
    input  logic [19:0]         i_traw,
    input  logic [15:0]         i_t1,
    input  logic signed [15:0]  i_t2,
    input  logic signed [15:0]  i_t3,
    output bpc_pkg::t_q         o_tf,
    output logic signed [14:0]  o_centi
);

    logic signed [20:0] r_ofs;
    logic signed [41:0] r_sq;
    logic signed [36:0] r_t2o;
    logic signed [36:0] r_t2o_d;
    logic signed [57:0] r_m;
    logic signed [57:0] r_num;
    bpc_pkg::t_q        r_tf;
    logic signed [14:0] r_centi;
    logic signed [60:0] n_c5;
    logic signed [18:0] n_cq;
    logic signed [14:0] n_centi;

    // num * 5 + half, floor by 2^42, clamp
    always_comb begin
        n_c5 = (61'(r_num) <<< 2) + 61'(r_num) + (61'sd1 <<< 41);
        n_cq = n_c5[60:42];
        if (n_cq < bpc_pkg::CENTI_MIN) begin
            n_centi = bpc_pkg::CENTI_MIN;
        end else if (n_cq > bpc_pkg::CENTI_MAX) begin
            n_centi = bpc_pkg::CENTI_MAX;
        end else begin
            n_centi = n_cq[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ofs   <= signed'({1'b0, i_traw}) - signed'({1'b0, i_t1, 4'b0});
        r_sq    <= r_ofs * r_ofs;
        r_t2o   <= i_t2 * r_ofs;
        r_m     <= r_sq * i_t3;
        r_t2o_d <= r_t2o;
        r_num   <= r_m + (58'(r_t2o_d) <<< 20);
        r_tf    <= (bpc_pkg::t_q'(r_num) >>> (34 - bpc_pkg::FRAC_BITS)) - bpc_pkg::TF_OFS;
        r_centi <= n_centi;
    end

    assign o_tf    = r_tf;
    assign o_centi = r_centi;

endmodule

[hdl/bpc_div.sv]
// Pipelined divider: -100000*n / d in fixed point, truncated and saturated.
// Magnitude stage, setup stage, DIV_STAGES restoring stages, sign stage; uses bpc_pkg.
module bpc_div (
    input  logic             i_clk,
    input  bpc_pkg::t_prod   i_prod,
    input  bpc_pkg::t_q      i_d,
    output bpc_pkg::t_q      o_pf
);

    logic [127:0] r_pm;
    logic [63:0]  r_dm0;
    logic         r_neg0;
    logic [127:0] n_num;
    logic [63:0]  r_rem [bpc_pkg::DIV_STAGES + 1];
    logic [63:0]  r_qn  [bpc_pkg::DIV_STAGES + 1];
    logic [63:0]  r_dm  [bpc_pkg::DIV_STAGES + 1];
    logic         r_ovf [bpc_pkg::DIV_STAGES + 1];
    logic         r_neg [bpc_pkg::DIV_STAGES + 1];
    bpc_pkg::t_q  r_pf;

    assign n_num = r_pm << bpc_pkg::FRAC_BITS;

    // magnitudes and quotient sign, then overflow check and setup
    always_ff @(posedge i_clk) begin
        r_pm     <= i_prod[127] ? 128'(-i_prod) : 128'(i_prod);
        r_dm0    <= i_d[63] ? 64'(-i_d) : 64'(i_d);
        r_neg0   <= ~i_prod[127] ^ i_d[63];
        r_ovf[0] <= (n_num >> 63) >= {64'b0, r_dm0};
        r_rem[0] <= n_num[127:64];
        r_qn[0]  <= n_num[63:0];
        r_dm[0]  <= r_dm0;
        r_neg[0] <= r_neg0;
    end

    // restoring stages, DIV_STEP quotient bits each
    for (genvar g = 1; g <= bpc_pkg::DIV_STAGES; g++) begin : g_div
        logic [63:0] n_rem;
        logic [63:0] n_qn;

        always_comb begin
            logic [64:0] trial;
            n_rem = r_rem[g-1];
            n_qn  = r_qn[g-1];
            for (int k = 0; k < bpc_pkg::DIV_STEP; k++) begin
                trial = {n_rem, n_qn[63]};
                n_qn  = {n_qn[62:0], 1'b0};
                if (trial >= {1'b0, r_dm[g-1]}) begin
                    trial   = trial - {1'b0, r_dm[g-1]};
                    n_qn[0] = 1'b1;
                end
                n_rem = trial[63:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_qn[g]  <= n_qn;
            r_dm[g]  <= r_dm[g-1];
            r_ovf[g] <= r_ovf[g-1];
            r_neg[g] <= r_neg[g-1];
        end
    end

    // apply sign, saturate on overflow
    always_ff @(posedge i_clk) begin
        if (r_ovf[bpc_pkg::DIV_STAGES]) begin
            r_pf <= r_neg[bpc_pkg::DIV_STAGES] ? bpc_pkg::Q_MIN : bpc_pkg::Q_MAX;
        end else if (r_neg[bpc_pkg::DIV_STAGES]) begin
            r_pf <= bpc_pkg::t_q'(-r_qn[bpc_pkg::DIV_STAGES]);
        end else begin
            r_pf <= bpc_pkg::t_q'(r_qn[bpc_pkg::DIV_STAGES]);
        end
    end

    assign o_pf = r_pf;

endmodule

[hdl/barometric_pressure_compensation.sv]
// Top level of the barometer compensation pipeline: config registers, pressure stages.
// Instantiates bpc_temp, bpc_mul, bpc_div; uses bpc_pkg.
//
//  channel   handshake                   payload
//  input     start & !busy               i_data (bpc_pkg::t_in)
//  result    o_valid, one-cycle strobe   o_result (bpc_pkg::t_out)
//  config    i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// One beat per cycle in; results leave in the order of their beats.
// The latency is set mainly by the 35-stage divider (32 stages of two quotient bits each) and
// the five 4-stage multipliers in series.
// Synchronous active-low reset clears the config registers and the valid line.
// busy stays low; results cannot be held off and nothing stalls.
module barometric_pressure_compensation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bpc_pkg::t_in     i_data,
    output logic             busy,
    output logic             o_valid,
    output bpc_pkg::t_out    o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data
);

    localparam int L_PRAW  = bpc_pkg::S_POST2;
    localparam int L_TF    = bpc_pkg::S_POST1 - bpc_pkg::S_TF;
    localparam int L_PF    = bpc_pkg::S_PR1 - bpc_pkg::S_PF;
    localparam int L_CENTI = bpc_pkg::S_PR2 - bpc_pkg::S_TF;
    localparam int L_FAULT = bpc_pkg::S_PR2 - bpc_pkg::S_DP;
    localparam int L_VLD   = bpc_pkg::S_PR2;

    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low;
    logic [63:0] r_press_mid;
    logic [15:0] r_press_high;

    logic                accept;
    logic [19:0]         n_praw;
    logic [19:0]         n_traw;
    logic [15:0]         t1;
    logic signed [15:0]  t2;
    logic signed [15:0]  t3;
    logic [15:0]         p1;
    logic signed [15:0]  p2, p3, p4, p5, p6, p7, p8, p9;
    bpc_pkg::t_q         c_x1;
    bpc_pkg::t_q         c_b;
    bpc_pkg::t_q         c_pr1;
    bpc_pkg::t_q         c_pr2;

    logic [19:0]         r_praw_dly  [L_PRAW];
    bpc_pkg::t_q         r_tf_dly    [L_TF];
    bpc_pkg::t_q         r_pf_dly    [L_PF];
    logic signed [14:0]  r_centi_dly [L_CENTI];
    logic                r_fault_dly [L_FAULT];
    logic [L_VLD-1:0]    r_vld;

    bpc_pkg::t_q    w_tf;
    logic signed [14:0] w_centi;
    bpc_pkg::t_prod w_p6p, w_p3p, w_x1p, w_bp, w_dp, w_np, w_p9p, w_prp;
    bpc_pkg::t_q    w_pf;
    bpc_pkg::t_q    n_d;

    bpc_pkg::t_q    r_x1a, r_b1, r_x1, r_b, r_n, r_d, r_pr1, r_pr2;
    logic           r_fault;
    logic           r_out_valid;
    bpc_pkg::t_out  r_out;
    bpc_pkg::t_q    n_pq;
    logic [24:0]    n_press;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_mid  <= '0;
            r_press_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bpc_pkg::REG_TEMP_TRIM:  r_temp_trim  <= i_cfg_data[47:0];
                bpc_pkg::REG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                bpc_pkg::REG_PRESS_MID:  r_press_mid  <= i_cfg_data;
                bpc_pkg::REG_PRESS_HIGH: r_press_high <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // trim words
    assign t1 = r_temp_trim[15:0];
    assign t2 = signed'(r_temp_trim[31:16]);
    assign t3 = signed'(r_temp_trim[47:32]);
    assign p1 = r_press_low[15:0];
    assign p2 = signed'(r_press_low[31:16]);
    assign p3 = signed'(r_press_low[47:32]);
    assign p4 = signed'(r_press_low[63:48]);
    assign p5 = signed'(r_press_mid[15:0]);
    assign p6 = signed'(r_press_mid[31:16]);
    assign p7 = signed'(r_press_mid[47:32]);
    assign p8 = signed'(r_press_mid[63:48]);
    assign p9 = signed'(r_press_high);

    // constant terms from the trims (small, never saturate)
    assign c_x1  = (bpc_pkg::t_q'(p4) <<< (bpc_pkg::FRAC_BITS + 4))
                   - (bpc_pkg::t_q'(1) <<< (bpc_pkg::FRAC_BITS + 20));
    assign c_b   = bpc_pkg::t_q'(16) <<< bpc_pkg::FRAC_BITS;
    assign c_pr1 = (bpc_pkg::t_q'(p8) <<< (bpc_pkg::FRAC_BITS - 19))
                   + (bpc_pkg::t_q'(1) <<< bpc_pkg::FRAC_BITS);
    assign c_pr2 = bpc_pkg::t_q'(p7) <<< (bpc_pkg::FRAC_BITS - 4);

    // raw value packing
    assign n_praw = {i_data.press_msb, i_data.press_lsb, i_data.press_xlsb[7:4]};
    assign n_traw = {i_data.temp_msb, i_data.temp_lsb, i_data.temp_xlsb[7:4]};

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[L_VLD-2:0], accept};
            r_out_valid <= r_vld[L_VLD-1];
        end
    end

    // side-data delay lines
    always_ff @(posedge i_clk) begin
        r_praw_dly[0]  <= n_praw;
        r_tf_dly[0]    <= w_tf;
        r_pf_dly[0]    <= w_pf;
        r_centi_dly[0] <= w_centi;
        r_fault_dly[0] <= r_fault;
        for (int k = 1; k < L_PRAW; k++) r_praw_dly[k] <= r_praw_dly[k-1];
        for (int k = 1; k < L_TF; k++) r_tf_dly[k] <= r_tf_dly[k-1];
        for (int k = 1; k < L_PF; k++) r_pf_dly[k] <= r_pf_dly[k-1];
        for (int k = 1; k < L_CENTI; k++) r_centi_dly[k] <= r_centi_dly[k-1];
        for (int k = 1; k < L_FAULT; k++) r_fault_dly[k] <= r_fault_dly[k-1];
    end

    bpc_temp u_temp (
        .i_clk   (i_clk),
        .i_traw  (n_traw),
        .i_t1    (t1),
        .i_t2    (t2),
        .i_t3    (t3),
        .o_tf    (w_tf),
        .o_centi (w_centi)
    );

    // inner terms of both polynomials in temperature
    bpc_mul u_mul_p6 (.i_clk(i_clk), .i_a(w_tf), .i_b(bpc_pkg::t_q'(p6)), .o_p(w_p6p));
    bpc_mul u_mul_p3 (.i_clk(i_clk), .i_a(w_tf), .i_b(bpc_pkg::t_q'(p3)), .o_p(w_p3p));

    always_ff @(posedge i_clk) begin
        r_x1a <= bpc_pkg::f_add(bpc_pkg::f_sat(w_p6p >>> 31),
                                bpc_pkg::t_q'(p5) <<< (bpc_pkg::FRAC_BITS - 14));
        r_b1  <= bpc_pkg::f_add(bpc_pkg::f_sat(w_p3p >>> 51),
                                bpc_pkg::t_q'(p2) <<< (bpc_pkg::FRAC_BITS - 31));
    end

    // outer terms
    bpc_mul u_mul_x1 (.i_clk(i_clk), .i_a(r_x1a), .i_b(r_tf_dly[L_TF-1]), .o_p(w_x1p));
    bpc_mul u_mul_b  (.i_clk(i_clk), .i_a(r_b1),  .i_b(r_tf_dly[L_TF-1]), .o_p(w_bp));

    always_ff @(posedge i_clk) begin
        r_x1 <= bpc_pkg::f_add(bpc_pkg::f_sat(w_x1p >>> bpc_pkg::FRAC_BITS), c_x1);
        r_b  <= bpc_pkg::f_add(bpc_pkg::f_sat(w_bp >>> bpc_pkg::FRAC_BITS), c_b);
        r_n  <= bpc_pkg::f_add(bpc_pkg::t_q'({44'b0, r_praw_dly[L_PRAW-1]})
                               <<< bpc_pkg::FRAC_BITS, r_x1);
    end

    // divisor and scaled numerator
    bpc_mul u_mul_d (.i_clk(i_clk), .i_a(r_b), .i_b(bpc_pkg::t_q'({48'b0, p1})), .o_p(w_dp));
    bpc_mul u_mul_n (.i_clk(i_clk), .i_a(r_n), .i_b(bpc_pkg::t_q'(100000)), .o_p(w_np));

    assign n_d = bpc_pkg::f_sat(w_dp);

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_fault <= (n_d == '0);
    end

    bpc_div u_div (
        .i_clk  (i_clk),
        .i_prod (w_np),
        .i_d    (r_d),
        .o_pf   (w_pf)
    );

    // pressure polynomial
    bpc_mul u_mul_p9 (.i_clk(i_clk), .i_a(w_pf), .i_b(bpc_pkg::t_q'(p9)), .o_p(w_p9p));

    always_ff @(posedge i_clk) begin
        r_pr1 <= bpc_pkg::f_add(bpc_pkg::f_sat(w_p9p >>> 35), c_pr1);
    end

    bpc_mul u_mul_pr (.i_clk(i_clk), .i_a(r_pr1), .i_b(r_pf_dly[L_PF-1]), .o_p(w_prp));

    always_ff @(posedge i_clk) begin
        r_pr2 <= bpc_pkg::f_add(bpc_pkg::f_sat(w_prp >>> bpc_pkg::FRAC_BITS), c_pr2);
    end

    // output scaling and clamp
    always_comb begin
        n_pq = r_pr2 >>> (bpc_pkg::FRAC_BITS - 8);
        if (r_fault_dly[L_FAULT-1] || n_pq[63]) begin
            n_press = '0;
        end else if (n_pq > bpc_pkg::t_q'({39'b0, bpc_pkg::PRESS_MAX})) begin
            n_press = bpc_pkg::PRESS_MAX;
        end else begin
            n_press = n_pq[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.temperature_centi <= r_centi_dly[L_CENTI-1];
        r_out.pressure_q8       <= n_press;
        r_out.divide_fault      <= r_fault_dly[L_FAULT-1];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hdl/bpc_check.sv]
// Port-level checks for the barometer compensation block, bound to the top level.
// Uses bpc_pkg for the pipeline latency and output bounds.
module bpc_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input bpc_pkg::t_out o_result
);

    // every beat yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(bpc_pkg::LATENCY) o_valid)
        else $error("result missing after input beat");

    // no result without a beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, bpc_pkg::LATENCY))
        else $error("result without matching input beat");

    // a zero divisor forces pressure to zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.divide_fault) |-> (o_result.pressure_q8 == '0))
        else $error("pressure nonzero on divide fault");

    // temperature stays within the clamp window
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.temperature_centi >= bpc_pkg::CENTI_MIN
                     && o_result.temperature_centi <= bpc_pkg::CENTI_MAX))
        else $error("temperature out of range");

endmodule

bind barometric_pressure_compensation bpc_check u_check (.*);
